// ===== hdl/gwd_pkg.sv =====
// Shared constants, codes and types for the grid wall dilation unit.
// Used by grid_wall_dilation_unit; gwd_ram does not depend on it.
`timescale 1ns / 1ps

package gwd_pkg;

   // grid geometry and limits
   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int MAX_RADIUS = 15;

   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int CELL_W     = 16;
   localparam int CNT_W      = 7;
   localparam int RAD_W      = 4;
   localparam int CELL_AW    = ROW_W + COL_W;
   localparam int CELL_DEPTH = MAX_COLS * MAX_ROWS;
   localparam int ROW_WORD_W = 2 * MAX_COLS;

   // register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // register reset values
   localparam logic [CNT_W-1:0]  COLS_RESET   = CNT_W'(64);
   localparam logic [CNT_W-1:0]  ROWS_RESET   = CNT_W'(64);
   localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(1);
   localparam logic [CELL_W-1:0] MARKER_RESET = CELL_W'(5);

   typedef enum logic [1:0] {
      REG_GRID_COLS    = 2'd0,
      REG_GRID_ROWS    = 2'd1,
      REG_RADIUS       = 2'd2,
      REG_MARKER_VALUE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_RUN   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OUTSIDE   = 2'd1,
      ST_NO_RADIUS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_SCAN_TAIL,
      S_HDIL,
      S_VRD,
      S_VTAIL,
      S_MARK
   } state_type;

endpackage

// ===== hdl/gwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the cell store and the row bitmap store.
`timescale 1ns / 1ps

module gwd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/grid_wall_dilation_unit.sv =====
// Top level of the grid wall dilation unit: register port, sequencer, row word unit.
// Depends on gwd_pkg and two gwd_ram instances (cell store, row bitmap store).
//
//   channel   ports                                   direction
//   -------   -------------------------------------   ---------
//   request   start, busy, req_opcode/col/row/value    in/out
//   result    rsp_strobe, rsp_read_value, rsp_status   out
//   csr       psel, penable, pwrite, paddr, pwdata,    in/out
//             prdata, pready
//
// Write, bad address, unused opcode, zero-radius or empty-grid run: result next cycle.
// Read: goes through S_READ (registered cell RAM read), then the result is registered.
// Run: one cell RAM port access per
// cell on the scan and on the mark pass, r shift steps and up to 2r+1 row reads per row.
// Reset is synchronous; busy is low right after reset. The receiver cannot stall:
// each result beat is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module grid_wall_dilation_unit
   import gwd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [COL_W-1:0]   req_col,
   input  logic [ROW_W-1:0]   req_row,
   input  logic [CELL_W-1:0]  req_cell_value,
   // result channel
   output logic               rsp_strobe,
   output logic [CELL_W-1:0]  rsp_read_value,
   output logic [1:0]         rsp_status,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   // configuration registers
   logic [CNT_W-1:0]  grid_cols_ff;
   logic [CNT_W-1:0]  grid_rows_ff;
   logic [RAD_W-1:0]  radius_ff;
   logic [CELL_W-1:0] marker_ff;

   // sequencer state
   state_type         state_ff,      state_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [CELL_W-1:0] rsp_value_ff,  rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [COL_W-1:0]  scol_ff,       scol_in;
   logic [ROW_W-1:0]  srow_ff,       srow_in;
   logic [RAD_W-1:0]  step_ff,       step_in;
   logic [ROW_W-1:0]  vy_ff,         vy_in;
   logic [MAX_COLS-1:0] spread_ff,   spread_in;
   logic [MAX_COLS-1:0] even_ff,     even_in;
   logic              cpend_ff,      cpend_in;
   logic [COL_W-1:0]  cpend_col_ff,  cpend_col_in;
   logic              rpend_ff,      rpend_in;
   logic [ROW_W-1:0]  rpend_row_ff,  rpend_row_in;

   // memory ports
   logic                  cell_we;
   logic [CELL_AW-1:0]    cell_waddr;
   logic [CELL_W-1:0]     cell_wdata;
   logic [CELL_AW-1:0]    cell_raddr;
   logic [CELL_W-1:0]     cell_rdata;
   logic                  row_we;
   logic [ROW_WORD_W-1:0] row_wdata;
   logic [ROW_WORD_W-1:0] row_rdata;

   // derived values
   logic                  accept;
   logic                  csr_write;
   logic [CNT_W-1:0]      cols_eff;
   logic [CNT_W-1:0]      rows_eff;
   logic [RAD_W-1:0]      r_eff;
   logic [COL_W-1:0]      last_col;
   logic [ROW_W-1:0]      last_row;
   logic                  in_grid;
   logic [MAX_COLS-1:0]   hdil_word;
   logic [ROW_W:0]        win_hi_sum;
   logic [ROW_W:0]        win_hi;
   logic [ROW_W:0]        next_w;
   logic [ROW_W:0]        r_ext;
   logic [ROW_W-1:0]      win_lo_next;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // clamp register values to the grid limits
   assign cols_eff = (grid_cols_ff > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : grid_cols_ff;
   assign rows_eff = (grid_rows_ff > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : grid_rows_ff;
   assign r_eff    = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;
   assign last_col = COL_W'(cols_eff - 1'b1);
   assign last_row = ROW_W'(rows_eff - 1'b1);
   assign in_grid  = ({1'b0, req_col} < cols_eff) && ({1'b0, req_row} < rows_eff);

   // vertical window of rows around the current row
   assign r_ext       = (ROW_W+1)'(r_eff);
   assign win_hi_sum  = {1'b0, srow_ff} + r_ext;
   assign win_hi      = (win_hi_sum < {1'b0, last_row}) ? win_hi_sum : {1'b0, last_row};
   assign next_w      = {1'b0, srow_ff} + 1'b1;
   assign win_lo_next = (next_w > r_ext) ? ROW_W'(next_w - r_ext) : '0;

   // shared row word unit: widen the spread bits by one column each way
   assign hdil_word = spread_ff | (spread_ff << 1) | (spread_ff >> 1);

   // register read mux
   always_comb begin
      unique case (csr_index_type'(paddr[3:2]))
         REG_GRID_COLS:    prdata = CSR_DW'(grid_cols_ff);
         REG_GRID_ROWS:    prdata = CSR_DW'(grid_rows_ff);
         REG_RADIUS:       prdata = CSR_DW'(radius_ff);
         REG_MARKER_VALUE: prdata = CSR_DW'(marker_ff);
      endcase
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= COLS_RESET;
         grid_rows_ff <= ROWS_RESET;
         radius_ff    <= RADIUS_RESET;
         marker_ff    <= MARKER_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(paddr[3:2]))
            REG_GRID_COLS:    grid_cols_ff <= pwdata[CNT_W-1:0];
            REG_GRID_ROWS:    grid_rows_ff <= pwdata[CNT_W-1:0];
            REG_RADIUS:       radius_ff    <= pwdata[RAD_W-1:0];
            REG_MARKER_VALUE: marker_ff    <= pwdata[CELL_W-1:0];
         endcase
      end
   end

   // next state and memory controls
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      scol_in       = scol_ff;
      srow_in       = srow_ff;
      step_in       = step_ff;
      vy_in         = vy_ff;
      spread_in     = spread_ff;
      even_in       = even_ff;
      cpend_in      = 1'b0;
      cpend_col_in  = scol_ff;
      rpend_in      = 1'b0;
      rpend_row_in  = vy_ff;
      cell_we       = 1'b0;
      cell_waddr    = {req_row, req_col};
      cell_wdata    = req_cell_value;
      cell_raddr    = {req_row, req_col};
      row_we        = 1'b0;
      row_wdata     = {even_ff, hdil_word};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_status_in = ST_OK;
               if (req_opcode == OP_WRITE || req_opcode == OP_READ) begin
                  if (!in_grid) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_OUTSIDE;
                  end else if (req_opcode == OP_WRITE) begin
                     cell_we       = 1'b1;
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in = S_READ;
                  end
               end else if (req_opcode == OP_RUN) begin
                  if (r_eff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_NO_RADIUS;
                  end else if (cols_eff == '0 || rows_eff == '0) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in  = S_SCAN;
                     srow_in   = '0;
                     scol_in   = '0;
                     spread_in = '0;
                     even_in   = '0;
                  end
               end else begin
                  // unused opcode: answer with an empty beat
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         S_READ: begin
            rsp_value_in  = cell_rdata;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            // issue one cell read per cycle along the row
            cell_raddr = {srow_ff, scol_ff};
            cpend_in   = 1'b1;
            if (scol_ff == last_col) begin
               state_in = S_SCAN_TAIL;
            end else begin
               scol_in = scol_ff + 1'b1;
            end
         end
         S_SCAN_TAIL: begin
            step_in  = '0;
            state_in = S_HDIL;
         end
         S_HDIL: begin
            // widen the row r times, then store it with its open-cell bits
            spread_in = hdil_word;
            step_in   = step_ff + 1'b1;
            if (step_ff == r_eff - 1'b1) begin
               row_we    = 1'b1;
               spread_in = '0;
               even_in   = '0;
               scol_in   = '0;
               if (srow_ff == last_row) begin
                  srow_in  = '0;
                  vy_in    = '0;
                  state_in = S_VRD;
               end else begin
                  srow_in  = srow_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_VRD: begin
            // read each stored row of the vertical window
            rpend_in = 1'b1;
            if ({1'b0, vy_ff} == win_hi) begin
               state_in = S_VTAIL;
            end else begin
               vy_in = vy_ff + 1'b1;
            end
         end
         S_VTAIL: begin
            scol_in  = '0;
            state_in = S_MARK;
         end
         S_MARK: begin
            // write the marker into open cells that have a wall in range
            cell_waddr = {srow_ff, scol_ff};
            cell_wdata = marker_ff;
            cell_we    = even_ff[scol_ff] && spread_ff[scol_ff];
            if (scol_ff == last_col) begin
               if (srow_ff == last_row) begin
                  rsp_strobe_in = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = ST_OK;
                  state_in      = S_IDLE;
               end else begin
                  srow_in   = srow_ff + 1'b1;
                  vy_in     = win_lo_next;
                  spread_in = '0;
                  even_in   = '0;
                  state_in  = S_VRD;
               end
            end else begin
               scol_in = scol_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // capture returning cell data into the row words
      if (cpend_ff) begin
         spread_in[cpend_col_ff] = cell_rdata[0] && (cell_rdata != marker_ff);
         even_in[cpend_col_ff]   = !cell_rdata[0];
      end

      // fold returning stored rows into the window sum
      if (rpend_ff) begin
         spread_in = spread_in | row_rdata[MAX_COLS-1:0];
         if (rpend_row_ff == srow_ff) begin
            even_in = row_rdata[ROW_WORD_W-1:MAX_COLS];
         end
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         cpend_ff      <= 1'b0;
         rpend_ff      <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         cpend_ff      <= cpend_in;
         rpend_ff      <= rpend_in;
      end
   end

   // payload and counters
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      scol_ff       <= scol_in;
      srow_ff       <= srow_in;
      step_ff       <= step_in;
      vy_ff         <= vy_in;
      spread_ff     <= spread_in;
      even_ff       <= even_in;
      cpend_col_ff  <= cpend_col_in;
      rpend_row_ff  <= rpend_row_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   // cell store
   gwd_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELL_DEPTH)
   ) u_cell_ram (
      .clock  (clock),
      .wr_en  (cell_we),
      .wr_addr(cell_waddr),
      .wr_data(cell_wdata),
      .rd_addr(cell_raddr),
      .rd_data(cell_rdata)
   );

   // row bitmap store: open-cell bits over widened wall bits
   gwd_ram #(
      .WIDTH(ROW_WORD_W),
      .DEPTH(MAX_ROWS)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (row_we),
      .wr_addr(srow_ff),
      .wr_data(row_wdata),
      .rd_addr(vy_ff),
      .rd_data(row_rdata)
   );

   // result beats only leave an idle sequencer
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // every accepted item either answers or starts work
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("accepted item neither answered nor started");

   // a valid run holds the request side off
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_RUN && r_eff != '0 && cols_eff != '0 && rows_eff != '0)
      |=> busy)
      else $error("run accepted but sequencer idle");

   // during a run the cell store is written only by the mark pass
   a_mark_only: assert property (@(posedge clock) disable iff (reset)
      (cell_we && state_ff != S_IDLE) |-> (state_ff == S_MARK))
      else $error("cell store written outside mark pass");

   // mark pass stays inside the grid
   a_mark_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (({1'b0, scol_ff} < cols_eff) && ({1'b0, srow_ff} < rows_eff)))
      else $error("mark pass outside grid");

endmodule
